// ===== rtl/basic_keyword_tokenizer_top_defines.svh =====
// Assertion macros used by the tokenizer controller.
`ifndef BASIC_KEYWORD_TOKENIZER_TOP_DEFINES_SVH
`define BASIC_KEYWORD_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bkt_pkg.sv =====
// ----------------------------------------------------------------------------
// bkt_pkg
// Types, codes and the keyword table of the keyword tokenizer.
// ----------------------------------------------------------------------------
package bkt_pkg;

  localparam int MAX_WORD_DEF = 14;
  localparam int KW_COUNT     = 110;
  localparam int KW_LEN_MAX   = 14;
  localparam int KW_IW        = 7;

  localparam logic [2:0] KIND_EOL   = 3'd0;
  localparam logic [2:0] KIND_OP    = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_NUM   = 3'd3;
  localparam logic [2:0] KIND_IDENT = 3'd4;
  localparam logic [2:0] KIND_KW    = 3'd5;
  localparam logic [2:0] KIND_EOF   = 3'd6;
  localparam logic [2:0] KIND_EMPTY = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_STRING = 3'd1,
    PH_NUMBER = 3'd2,
    PH_WORD   = 3'd3,
    PH_LONG   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_STORE, OP_PUSH, OP_CLOSE, OP_IDLECHAR,
    OP_LOOK, OP_KW, OP_IDS, OP_DUMP, OP_EOF
  } op_t;

  typedef struct packed {
    logic is_end;
    logic quote;
    logic digit;
    logic dot;
    logic wordch;
  } cls_t;

  typedef struct packed {
    phase_t phase;
    cls_t   live;
    logic   full;
    logic   hit;
    logic   kw_last;
    logic   pos_last;
    logic   out_free;
  } status_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic go;
  } cmd_t;

  typedef struct packed {
    logic [8*KW_LEN_MAX-1:0] text;
    logic [3:0]              len;
    logic [7:0]              code;
  } kw_ent_t;

  function automatic logic [7:0] up8(logic [7:0] c);
    if (c >= "a" && c <= "z") return c - 8'd32;
    return c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Text is right aligned: the last character sits in the low byte.
  function automatic kw_ent_t kw_make(logic [8*KW_LEN_MAX-1:0] t, logic [7:0] c);
    kw_ent_t e;
    e.text = t;
    e.code = c;
    e.len  = 4'd0;
    for (int k = 0; k < KW_LEN_MAX; k++) begin
      if (t[k*8 +: 8] != 8'd0) e.len = 4'(k + 1);
    end
    return e;
  endfunction

  function automatic kw_ent_t kw_at(logic [KW_IW-1:0] i);
    case (i)
      7'd0:   return kw_make("END", 8'h80);
      7'd1:   return kw_make("FOR", 8'h81);
      7'd2:   return kw_make("NEXT", 8'h82);
      7'd3:   return kw_make("DATA", 8'h83);
      7'd4:   return kw_make("INPUT", 8'h84);
      7'd5:   return kw_make("DIM", 8'h85);
      7'd6:   return kw_make("READ", 8'h86);
      7'd7:   return kw_make("LET", 8'h87);
      7'd8:   return kw_make("GOTO", 8'h88);
      7'd9:   return kw_make("RUN", 8'h89);
      7'd10:  return kw_make("IF", 8'h8A);
      7'd11:  return kw_make("RESTORE", 8'h8B);
      7'd12:  return kw_make("GOSUB", 8'h8C);
      7'd13:  return kw_make("RETURN", 8'h8D);
      7'd14:  return kw_make("REM", 8'h8E);
      7'd15:  return kw_make("STOP", 8'h8F);
      7'd16:  return kw_make("ON", 8'h90);
      7'd17:  return kw_make("WAIT", 8'h91);
      7'd18:  return kw_make("LOAD", 8'h92);
      7'd19:  return kw_make("SAVE", 8'h93);
      7'd20:  return kw_make("VERIFY", 8'h94);
      7'd21:  return kw_make("DEF", 8'h95);
      7'd22:  return kw_make("POKE", 8'h96);
      7'd23:  return kw_make("PRINT", 8'h99);
      7'd24:  return kw_make("CONT", 8'h9A);
      7'd25:  return kw_make("LIST", 8'h9B);
      7'd26:  return kw_make("CLR", 8'h9C);
      7'd27:  return kw_make("CMD", 8'h9D);
      7'd28:  return kw_make("SYS", 8'h9E);
      7'd29:  return kw_make("OPEN", 8'h9F);
      7'd30:  return kw_make("CLOSE", 8'hA0);
      7'd31:  return kw_make("NEW", 8'hA1);
      7'd32:  return kw_make("APPEND", 8'hA2);
      7'd33:  return kw_make("DLOAD", 8'hA3);
      7'd34:  return kw_make("GET", 8'hA4);
      7'd35:  return kw_make("GETKEY", 8'hA5);
      7'd36:  return kw_make("BANK", 8'hA6);
      7'd37:  return kw_make("BSAVE", 8'hA7);
      7'd38:  return kw_make("BLOAD", 8'hA8);
      7'd39:  return kw_make("RECORD", 8'hA9);
      7'd40:  return kw_make("CONCAT", 8'hAA);
      7'd41:  return kw_make("DVERIFY", 8'hAB);
      7'd42:  return kw_make("DCLEAR", 8'hAC);
      7'd43:  return kw_make("PALETTE", 8'hAD);
      7'd44:  return kw_make("BVERIFY", 8'hAE);
      7'd45:  return kw_make("DPATCH", 8'hAF);
      7'd46:  return kw_make("FETCH", 8'hB0);
      7'd47:  return kw_make("FIRST", 8'hB1);
      7'd48:  return kw_make("CARTRIDGE", 8'hB2);
      7'd49:  return kw_make("ROLLOVER", 8'hB3);
      7'd50:  return kw_make("RESET", 8'hB4);
      7'd51:  return kw_make("FLUSHBUFFER", 8'hB5);
      7'd52:  return kw_make("KEYBOARDCODING", 8'hB6);
      7'd53:  return kw_make("ELSE", 8'hB7);
      7'd54:  return kw_make("QUIT", 8'hB8);
      7'd55:  return kw_make("MID", 8'hC6);
      7'd56:  return kw_make("LEN", 8'hC7);
      7'd57:  return kw_make("STR", 8'hC8);
      7'd58:  return kw_make("VAL", 8'hC9);
      7'd59:  return kw_make("ASC", 8'hCA);
      7'd60:  return kw_make("CHR", 8'hCB);
      7'd61:  return kw_make("PEEK", 8'hCC);
      7'd62:  return kw_make("ABS", 8'hCD);
      7'd63:  return kw_make("INT", 8'hCE);
      7'd64:  return kw_make("SQR", 8'hCF);
      7'd65:  return kw_make("RND", 8'hD0);
      7'd66:  return kw_make("SIN", 8'hD1);
      7'd67:  return kw_make("COS", 8'hD2);
      7'd68:  return kw_make("TAN", 8'hD3);
      7'd69:  return kw_make("ATN", 8'hD4);
      7'd70:  return kw_make("EXP", 8'hD5);
      7'd71:  return kw_make("LOG", 8'hD6);
      7'd72:  return kw_make("SGN", 8'hD7);
      7'd73:  return kw_make("TAB", 8'hD8);
      7'd74:  return kw_make("THEN", 8'hD9);
      7'd75:  return kw_make("TO", 8'hDA);
      7'd76:  return kw_make("AND", 8'hDB);
      7'd77:  return kw_make("OR", 8'hDC);
      7'd78:  return kw_make("NOT", 8'hDD);
      7'd79:  return kw_make("STEP", 8'hDE);
      7'd80:  return kw_make("UNTIL", 8'hDF);
      7'd81:  return kw_make("WHILE", 8'hE0);
      7'd82:  return kw_make("REPEAT", 8'hE1);
      7'd83:  return kw_make("DO", 8'hE2);
      7'd84:  return kw_make("LOOP", 8'hE3);
      7'd85:  return kw_make("EXIT", 8'hE4);
      7'd86:  return kw_make("CALL", 8'hE5);
      7'd87:  return kw_make("TYPE", 8'hE6);
      7'd88:  return kw_make("MOD", 8'hE7);
      7'd89:  return kw_make("EXOR", 8'hE8);
      7'd90:  return kw_make("BAND", 8'hE9);
      7'd91:  return kw_make("BOR", 8'hEA);
      7'd92:  return kw_make("LSHIFT", 8'hEB);
      7'd93:  return kw_make("RSHIFT", 8'hEC);
      7'd94:  return kw_make("FRACT", 8'hED);
      7'd95:  return kw_make("PDUMP", 8'hEE);
      7'd96:  return kw_make("PLOAD", 8'hEF);
      7'd97:  return kw_make("PSAVE", 8'hF0);
      7'd98:  return kw_make("PTEST", 8'hF1);
      7'd99:  return kw_make("MULTI", 8'hF2);
      7'd100: return kw_make("MONITOR", 8'hF3);
      7'd101: return kw_make("UNTIL2", 8'hF4);
      7'd102: return kw_make("HEX", 8'hF5);
      7'd103: return kw_make("DOKE", 8'hF6);
      7'd104: return kw_make("DPEEK", 8'hF7);
      7'd105: return kw_make("FORMAT", 8'hF8);
      7'd106: return kw_make("CIRCLE", 8'hF9);
      7'd107: return kw_make("RECT", 8'hFA);
      7'd108: return kw_make("SPRDEF", 8'hFB);
      default: return kw_make('0, 8'h00);
    endcase
  endfunction

endpackage

// ===== rtl/bkt_dp.sv =====
// ----------------------------------------------------------------------------
// bkt_dp
// Tokenizer datapath: scan state, word buffer, keyword compare, output word.
// ----------------------------------------------------------------------------
module bkt_dp import bkt_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_source_char,
  input  logic       in_source_end,
  input  cmd_t       cmd,
  output status_t    st,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_token_value,
  output logic       out_token_first,
  output logic       out_token_last
);

  localparam int PW = $clog2(MAX_WORD);
  localparam int CW = $clog2(MAX_WORD + 1);

  logic [7:0]    c_r, c_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    store_r [MAX_WORD];
  logic          st_we;
  logic [PW-1:0] st_wa;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    held_char_r, held_char_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic          held_first_r, held_first_nxt;
  logic [KW_IW-1:0] kw_idx_r, kw_idx_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    code_r, code_nxt;
  logic          out_valid_r;
  logic [2:0]    kind_r;
  logic [7:0]    value_r;
  logic          first_r, last_r;

  logic          emit, e_f, e_l;
  logic [2:0]    e_kind, skind;
  logic [7:0]    e_val;
  kw_ent_t       ent;
  logic          hit, pos_last;

  // Keyword compare against one table entry per cycle.
  always_comb begin
    ent = kw_at(kw_idx_r);
    hit = (count_r == CW'(ent.len));
    for (int i = 0; i < KW_LEN_MAX; i++) begin
      if (4'(i) < ent.len) begin
        if (ent.text[(int'(ent.len) - 1 - i)*8 +: 8] != up8(store_r[i])) hit = 1'b0;
      end
    end
  end

  assign pos_last = ({1'b0, pos_r} + (PW+1)'(1)) == (PW+1)'(count_r);
  assign skind = (phase_r == PH_STRING) ? KIND_STR :
                 (phase_r == PH_NUMBER) ? KIND_NUM : KIND_IDENT;

  always_comb begin
    c_nxt = c_r; phase_nxt = phase_r; count_nxt = count_r;
    held_char_nxt = held_char_r; held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r; kw_idx_nxt = kw_idx_r; pos_nxt = pos_r;
    code_nxt = code_r;
    st_we = 1'b0; st_wa = count_r[PW-1:0];
    emit = 1'b0; e_kind = KIND_EOL; e_val = 8'd0; e_f = 1'b1; e_l = 1'b1;
    if (cmd.load) begin
      c_nxt = in_source_char;
      kw_idx_nxt = '0;
      pos_nxt = '0;
    end
    if (cmd.go) begin
      case (cmd.op)
        OP_STORE: begin
          st_we = 1'b1;
          count_nxt = count_r + CW'(1);
        end
        OP_PUSH: begin
          emit = held_valid_r; e_kind = skind; e_val = held_char_r;
          e_f = held_first_r; e_l = 1'b0;
          held_first_nxt = !held_valid_r;
          held_char_nxt = c_r;
          held_valid_nxt = 1'b1;
        end
        OP_CLOSE: begin
          if (held_valid_r) begin
            emit = 1'b1; e_kind = skind; e_val = held_char_r; e_f = held_first_r;
          end else if (phase_r == PH_STRING) begin
            emit = 1'b1; e_kind = KIND_EMPTY;
          end
          held_valid_nxt = 1'b0; held_first_nxt = 1'b0; phase_nxt = PH_IDLE;
        end
        OP_IDLECHAR: begin
          if (is_space(c_r)) begin
            emit = (c_r == 8'h0A);
          end else if (c_r == "\"") begin
            phase_nxt = PH_STRING; held_valid_nxt = 1'b0;
          end else if (is_digit(c_r)) begin
            phase_nxt = PH_NUMBER; held_first_nxt = 1'b1;
            held_char_nxt = c_r; held_valid_nxt = 1'b1;
          end else if (is_alpha(c_r) || c_r == "_") begin
            phase_nxt = PH_WORD; st_we = 1'b1; st_wa = '0; count_nxt = CW'(1);
          end else begin
            emit = 1'b1; e_kind = KIND_OP; e_val = c_r;
          end
        end
        OP_LOOK: begin
          if (hit) code_nxt = ent.code;
          kw_idx_nxt = kw_idx_r + KW_IW'(1);
        end
        OP_KW: begin
          emit = 1'b1; e_kind = KIND_KW; e_val = code_r;
          count_nxt = '0; phase_nxt = PH_IDLE;
        end
        OP_IDS: begin
          emit = 1'b1; e_kind = KIND_IDENT; e_val = store_r[pos_r];
          e_f = (pos_r == '0); e_l = pos_last;
          pos_nxt = pos_r + PW'(1);
          if (pos_last) begin
            count_nxt = '0; phase_nxt = PH_IDLE;
          end
        end
        OP_DUMP: begin
          emit = 1'b1; e_kind = KIND_IDENT; e_val = store_r[pos_r];
          e_f = (pos_r == '0); e_l = 1'b0;
          pos_nxt = pos_r + PW'(1);
          if (pos_last) begin
            count_nxt = '0; phase_nxt = PH_LONG; held_char_nxt = c_r;
            held_valid_nxt = 1'b1; held_first_nxt = 1'b0;
          end
        end
        OP_EOF: begin
          emit = 1'b1; e_kind = KIND_EOF;
          phase_nxt = PH_IDLE; count_nxt = '0; held_char_nxt = 8'd0;
          held_valid_nxt = 1'b0; held_first_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      held_char_r <= 8'd0;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      held_char_r <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      held_first_r <= held_first_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    kw_idx_r <= kw_idx_nxt;
    pos_r <= pos_nxt;
    code_r <= code_nxt;
    if (st_we) store_r[st_wa] <= c_r;
    if (emit) begin
      kind_r <= e_kind;
      value_r <= e_val;
      first_r <= e_f;
      last_r <= e_l;
    end
  end

  always_comb begin
    st.phase = phase_r;
    st.live.is_end = in_source_end;
    st.live.quote = (in_source_char == "\"");
    st.live.digit = is_digit(in_source_char);
    st.live.dot = (in_source_char == ".");
    st.live.wordch = is_alpha(in_source_char) || is_digit(in_source_char) ||
                     (in_source_char == "_");
    st.full = (count_r == CW'(MAX_WORD));
    st.hit = hit;
    st.kw_last = (kw_idx_r == KW_IW'(KW_COUNT - 1));
    st.pos_last = pos_last;
    st.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_token_kind = kind_r;
  assign out_token_value = value_r;
  assign out_token_first = first_r;
  assign out_token_last = last_r;

endmodule

// ===== rtl/bkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bkt_ctrl
// Tokenizer controller: picks the step sequence for each accepted word.
// ----------------------------------------------------------------------------
`include "basic_keyword_tokenizer_top_defines.svh"

module bkt_ctrl import bkt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_STORE = 10'b0000000010,
    S_PUSH  = 10'b0000000100,
    S_CLOSE = 10'b0000001000,
    S_ICHAR = 10'b0000010000,
    S_LOOK  = 10'b0000100000,
    S_KW    = 10'b0001000000,
    S_IDS   = 10'b0010000000,
    S_DUMP  = 10'b0100000000,
    S_EOF   = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {AF_DONE, AF_ICHAR, AF_EOF} after_t;

  state_t state_r, state_nxt, tail;
  after_t after_r, after_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    case (after_r)
      AF_ICHAR: tail = S_ICHAR;
      AF_EOF:   tail = S_EOF;
      default:  tail = S_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    cmd.load = accept;
    cmd.op = OP_NONE;
    cmd.go = st.out_free;
    case (state_r)
      S_IDLE: begin
        cmd.go = 1'b1;
        if (accept) begin
          after_nxt = AF_DONE;
          if (st.live.is_end) begin
            after_nxt = AF_EOF;
            case (st.phase)
              PH_WORD: state_nxt = S_LOOK;
              PH_IDLE: state_nxt = S_EOF;
              default: state_nxt = S_CLOSE;
            endcase
          end else begin
            case (st.phase)
              PH_STRING: state_nxt = st.live.quote ? S_CLOSE : S_PUSH;
              PH_NUMBER: begin
                if (st.live.digit || st.live.dot) state_nxt = S_PUSH;
                else begin
                  state_nxt = S_CLOSE; after_nxt = AF_ICHAR;
                end
              end
              PH_WORD: begin
                if (st.live.wordch) state_nxt = st.full ? S_DUMP : S_STORE;
                else begin
                  state_nxt = S_LOOK; after_nxt = AF_ICHAR;
                end
              end
              PH_LONG: begin
                if (st.live.wordch) state_nxt = S_PUSH;
                else begin
                  state_nxt = S_CLOSE; after_nxt = AF_ICHAR;
                end
              end
              default: state_nxt = S_ICHAR;
            endcase
          end
        end
      end
      S_STORE: begin
        cmd.op = OP_STORE; cmd.go = 1'b1; state_nxt = S_IDLE;
      end
      S_PUSH: begin
        cmd.op = OP_PUSH;
        if (st.out_free) state_nxt = S_IDLE;
      end
      S_CLOSE: begin
        cmd.op = OP_CLOSE;
        if (st.out_free) state_nxt = tail;
      end
      S_ICHAR: begin
        cmd.op = OP_IDLECHAR;
        if (st.out_free) state_nxt = S_IDLE;
      end
      S_LOOK: begin
        cmd.op = OP_LOOK; cmd.go = 1'b1;
        if (st.hit) state_nxt = S_KW;
        else if (st.kw_last) state_nxt = S_IDS;
      end
      S_KW: begin
        cmd.op = OP_KW;
        if (st.out_free) state_nxt = tail;
      end
      S_IDS: begin
        cmd.op = OP_IDS;
        if (st.out_free && st.pos_last) state_nxt = tail;
      end
      S_DUMP: begin
        cmd.op = OP_DUMP;
        if (st.out_free && st.pos_last) state_nxt = S_IDLE;
      end
      S_EOF: begin
        cmd.op = OP_EOF;
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= AF_DONE;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
    end
  end

  `BKT_ASSERT_NXT(a_busy_after_accept, accept, !in_ready, "ready held after accept")
  `BKT_ASSERT_NXT(a_hit_to_kw, (state_r == S_LOOK) && st.hit, state_r == S_KW, "hit lost")
  `BKT_ASSERT_IMP(a_emit_needs_room, cmd.go && (state_r == S_KW || state_r == S_IDS ||
    state_r == S_EOF || state_r == S_DUMP), st.out_free, "emit without room")
  `BKT_ASSERT_NXT(a_eof_to_idle, (state_r == S_EOF) && st.out_free, in_ready,
    "no return after end")

endmodule

// ===== rtl/basic_keyword_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// basic_keyword_tokenizer_top
// Streaming tokenizer with whole-word keyword crunching.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_ready  | source_char, source_end
//   out_     | output    | out_valid / out_ready| token_kind/value/first/last
//
// Sequence: a plain character is accepted, then handled by one controller step.
// A word end adds the keyword compare, one table entry per cycle until a hit
// or the last entry, then the identifier characters if no entry matched.
// Reset: rst_n low synchronously returns the scanner to idle between tokens.
// Stalls: each emitting step waits while the output word is held unaccepted;
// the single output register lets the next step run as the last word drains.
// ----------------------------------------------------------------------------
module basic_keyword_tokenizer_top import bkt_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_source_char,
  input  logic       in_source_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_token_value,
  output logic       out_token_first,
  output logic       out_token_last
);

  cmd_t    cmd;
  status_t st;

  // Sequence the steps of each accepted word.
  bkt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold scan state, the word buffer and the output word.
  bkt_dp #(.MAX_WORD(MAX_WORD)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_source_char  (in_source_char),
    .in_source_end   (in_source_end),
    .cmd             (cmd),
    .st              (st),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_token_first (out_token_first),
    .out_token_last  (out_token_last)
  );

endmodule

// ===== bench/tb_basic_keyword_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_basic_keyword_tokenizer_top
// Feeds source text and end marks into the tokenizer, predicts every token
// element in the bench and checks the output words in order.
// ----------------------------------------------------------------------------
module tb_basic_keyword_tokenizer_top;
  import bkt_pkg::*;

  localparam int WORD_MAX  = 14;
  localparam int STALL_CAP = 20000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       first;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } src_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_source_char;
  logic       in_source_end;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_token_kind;
  logic [7:0] out_token_value;
  logic       out_token_first;
  logic       out_token_last;

  basic_keyword_tokenizer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_source_char(in_source_char), .in_source_end(in_source_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_token_kind(out_token_kind), .out_token_value(out_token_value),
    .out_token_first(out_token_first), .out_token_last(out_token_last)
  );

  src_t   src_q[$];
  token_t tok_q[$];
  int     err_cnt;
  int     idle_cycles;
  bit     feed_done;

  // Scanner copy kept by the bench
  phase_t     sc_phase;
  logic [7:0] sc_word[WORD_MAX];
  int         sc_count;
  logic [7:0] sc_held;
  bit         sc_hvalid;
  bit         sc_hfirst;

  string kw_text[110];
  byte   kw_code[110];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void add_tok(logic [2:0] k, logic [7:0] v, bit f, bit l);
    token_t t;
    t.kind = k; t.value = v; t.first = f; t.last = l;
    tok_q = {tok_q, t};
  endfunction

  function automatic bit is_word_ch(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic [2:0] stream_kind();
    if (sc_phase == PH_STRING) return KIND_STR;
    if (sc_phase == PH_NUMBER) return KIND_NUM;
    return KIND_IDENT;
  endfunction

  function automatic void push_ch(logic [7:0] c);
    bit was;
    was = sc_hvalid;
    if (was) add_tok(stream_kind(), sc_held, sc_hfirst, 1'b0);
    sc_hfirst = !was;
    sc_held   = c;
    sc_hvalid = 1;
  endfunction

  function automatic void close_run();
    if (sc_hvalid) add_tok(stream_kind(), sc_held, sc_hfirst, 1'b1);
    else if (sc_phase == PH_STRING) add_tok(KIND_EMPTY, 8'd0, 1'b1, 1'b1);
    sc_hvalid = 0; sc_hfirst = 0; sc_phase = PH_IDLE;
  endfunction

  function automatic int kw_find();
    string s;
    logic [7:0] c;
    s = "";
    for (int i = 0; i < sc_count; i++) begin
      c = sc_word[i];
      if (c >= "a" && c <= "z") c = c - 8'd32;
      s = {s, string'(c)};
    end
    for (int k = 0; k < 110; k++) if (kw_text[k] == s && s.len() > 0) return k;
    return -1;
  endfunction

  function automatic void end_word();
    int k;
    if (sc_count > 0) begin
      k = kw_find();
      if (k >= 0) add_tok(KIND_KW, kw_code[k], 1'b1, 1'b1);
      else for (int i = 0; i < sc_count; i++)
        add_tok(KIND_IDENT, sc_word[i], i == 0, i + 1 == sc_count);
    end
    sc_count = 0; sc_phase = PH_IDLE;
  endfunction

  function automatic void start_tok(logic [7:0] c);
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      if (c == 8'd10) add_tok(KIND_EOL, 8'd0, 1'b1, 1'b1);
    end else if (c == "\"") begin
      sc_phase = PH_STRING; sc_hvalid = 0;
    end else if (c >= "0" && c <= "9") begin
      sc_phase = PH_NUMBER; sc_hvalid = 0; push_ch(c);
    end else if (is_word_ch(c)) begin
      sc_phase = PH_WORD; sc_word[0] = c; sc_count = 1;
    end else add_tok(KIND_OP, c, 1'b1, 1'b1);
  endfunction

  function automatic void sc_clear();
    sc_phase = PH_IDLE; sc_count = 0; sc_held = 0; sc_hvalid = 0; sc_hfirst = 0;
  endfunction

  // Predict the elements caused by one accepted input word
  function automatic void predict_tokens(src_t s);
    logic [7:0] c;
    c = s.ch;
    if (s.fin) begin
      if (sc_phase == PH_WORD) end_word();
      else if (sc_phase != PH_IDLE) close_run();
      add_tok(KIND_EOF, 8'd0, 1'b1, 1'b1);
      sc_clear();
      return;
    end
    case (sc_phase)
      PH_STRING: if (c == "\"") close_run(); else push_ch(c);
      PH_NUMBER: if ((c >= "0" && c <= "9") || c == ".") push_ch(c);
                 else begin close_run(); start_tok(c); end
      PH_WORD: begin
        if (is_word_ch(c)) begin
          if (sc_count < WORD_MAX) begin
            sc_word[sc_count] = c; sc_count++;
          end else begin
            for (int i = 0; i < WORD_MAX; i++)
              add_tok(KIND_IDENT, sc_word[i], i == 0, 1'b0);
            sc_count = 0; sc_phase = PH_LONG;
            sc_held = c; sc_hvalid = 1; sc_hfirst = 0;
          end
        end else begin
          end_word(); start_tok(c);
        end
      end
      PH_LONG: if (is_word_ch(c)) push_ch(c);
               else begin close_run(); start_tok(c); end
      default: begin sc_phase = PH_IDLE; start_tok(c); end
    endcase
  endfunction

  task automatic queue_text(string s);
    src_t e;
    for (int i = 0; i < s.len(); i++) begin
      e.ch = s[i]; e.fin = 0; src_q = {src_q, e};
    end
  endtask

  task automatic queue_char(logic [7:0] c, bit fin);
    src_t e;
    e.ch = c; e.fin = fin; src_q = {src_q, e};
  endtask

  // Driver: hold each word until accepted, draw a gap before the next
  int drv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_source_char <= 8'd0;
      in_source_end <= 1'b0;
      drv_gap <= $urandom_range(0, 19);
    end else if (in_valid && !in_ready) begin
      // hold
    end else begin
      if (in_valid) predict_tokens('{in_source_char, in_source_end});
      if (drv_gap > 0 || src_q.size() == 0) begin
        in_valid <= 1'b0;
        if (drv_gap > 0) drv_gap <= drv_gap - 1;
      end else begin
        src_t e;
        e = src_q.pop_front();
        in_valid <= 1'b1;
        in_source_char <= e.ch;
        in_source_end <= e.fin;
        drv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
    end
  end

  // Monitor: compare each accepted output word with the oldest prediction
  int mon_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      mon_gap <= 0;
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (tok_q.size() == 0) report("output word with nothing expected");
        else begin
          token_t t;
          t = tok_q.pop_front();
          if (out_token_kind !== t.kind)
            report($sformatf("kind %0d, expected %0d", out_token_kind, t.kind));
          if (out_token_value !== t.value)
            report($sformatf("value %02h, expected %02h", out_token_value, t.value));
          if (out_token_first !== t.first)
            report($sformatf("first %b, expected %b", out_token_first, t.first));
          if (out_token_last !== t.last)
            report($sformatf("last %b, expected %b", out_token_last, t.last));
        end
        mon_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        out_ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= STALL_CAP) begin
      $display("timeout: no handshake for %0d cycles", STALL_CAP);
      $display("*** FAILED ***");
      $finish;
    end
  end

  string kw_list;
  string alpha, rnd_s;
  string sep_kw, sep_id, num_set, ws_set;
  int    pick, n;

  initial begin
    kw_list = {"END FOR NEXT DATA INPUT DIM READ LET GOTO RUN IF RESTORE GOSUB ",
      "RETURN REM STOP ON WAIT LOAD SAVE VERIFY DEF POKE PRINT CONT LIST CLR CMD ",
      "SYS OPEN CLOSE NEW APPEND DLOAD GET GETKEY BANK BSAVE BLOAD RECORD CONCAT ",
      "DVERIFY DCLEAR PALETTE BVERIFY DPATCH FETCH FIRST CARTRIDGE ROLLOVER RESET ",
      "FLUSHBUFFER KEYBOARDCODING ELSE QUIT MID LEN STR VAL ASC CHR PEEK ABS INT ",
      "SQR RND SIN COS TAN ATN EXP LOG SGN TAB THEN TO AND OR NOT STEP UNTIL WHILE ",
      "REPEAT DO LOOP EXIT CALL TYPE MOD EXOR BAND BOR LSHIFT RSHIFT FRACT PDUMP ",
      "PLOAD PSAVE PTEST MULTI MONITOR UNTIL2 HEX DOKE DPEEK FORMAT CIRCLE RECT ",
      "SPRDEF "};
    n = 0; alpha = "";
    for (int i = 0; i < kw_list.len(); i++) begin
      if (kw_list[i] == " ") begin kw_text[n] = alpha; alpha = ""; n++; end
      else alpha = {alpha, string'(kw_list[i])};
    end
    // codes: a run from 0x80 with the gaps the table leaves
    for (int k = 0; k < n; k++)
      kw_code[k] = byte'((k < 23) ? 8'h80 + k :
                         (k < 55) ? 8'h99 + (k - 23) : 8'hC6 + (k - 55));
    for (int k = n; k < 110; k++) begin kw_text[k] = "\001"; kw_code[k] = 0; end

    sep_kw  = " :(\n";
    sep_id  = " +\n";
    num_set = "0123456789.";
    ws_set  = " \t\r\n";

    err_cnt = 0; feed_done = 0;
    sc_clear();
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: keywords in both cases, numbers, strings, empty and open string,
    // high bytes, colon, overlong word, keyword longest entry
    queue_text("print 10:\"\"");
    queue_char(8'd10, 0);
    queue_text("KEYBOARDCODING 3.14 \"a\xff\" \x80\xff;");
    queue_text("KEYBOARDCODINGX _x9 ");
    queue_text("\"open");
    queue_char(8'h00, 1);
    queue_char(8'h7f, 1);

    alpha = "abcxyzABCXYZ_0189";
    for (int it = 0; it < 90; it++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        rnd_s = kw_text[$urandom_range(0, n - 1)];
        for (int i = 0; i < rnd_s.len(); i++)
          if ($urandom_range(0, 1)) rnd_s[i] = rnd_s[i] + 8'd32;
        queue_text(rnd_s);
        queue_char(sep_kw[$urandom_range(0, 3)], 0);
      end else if (pick < 5) begin
        queue_char(8'("a" + $urandom_range(0, 25)), 0);
        for (int i = $urandom_range(0, ($urandom_range(0, 5) == 0) ? 20 : 6); i > 0; i--)
          queue_char(alpha[$urandom_range(0, alpha.len() - 1)], 0);
        queue_char(sep_id[$urandom_range(0, 2)], 0);
      end else if (pick == 5) begin
        queue_char("\"", 0);
        for (int i = $urandom_range(0, 5); i > 0; i--)
          queue_char(8'($urandom_range(0, 255)), 0);
        if ($urandom_range(0, 3) != 0) queue_char("\"", 0);
      end else if (pick == 6) begin
        for (int i = $urandom_range(1, 5); i > 0; i--)
          queue_char(num_set[$urandom_range(0, 10)], 0);
      end else if (pick == 7) begin
        queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else if (pick == 8) queue_char(8'($urandom_range(0, 255)), 0);
      else queue_char(ws_set[$urandom_range(0, 3)], 0);
    end
    queue_char(8'($urandom_range(0, 255)), 1);

    wait (src_q.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    while (tok_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && tok_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
